// File: hdl/irpte_pkg.sv
// Package with the shared constants and register indexes of the IR pulse train encoder.
package irpte_pkg;

  localparam int unsigned PULSE_SLOTS = 4;
  localparam int unsigned PULSE_WIDTH = 16;
  localparam int unsigned LIST_WIDTH  = PULSE_SLOTS * PULSE_WIDTH;
  localparam int unsigned SLOT_IDX_W  = (PULSE_SLOTS > 1) ? $clog2(PULSE_SLOTS) : 1;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_PULSES = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_PULSES   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ONE_PULSES    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TRAIL_PULSES  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RAW_PULSES    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_BITS    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_RAW_BIT_INDEX = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_RAW_ENABLE    = 3'd7;

  localparam logic [7:0] FRAME_BITS_RESET = 8'd32;
  localparam logic [7:0] BITS_PER_BYTE    = 8'd8;

  localparam logic [SLOT_IDX_W-1:0] LAST_SLOT = SLOT_IDX_W'(PULSE_SLOTS - 1);

endpackage

// File: hdl/ir_pulse_train_encoder.sv
// Top level of the IR pulse train encoder: command bytes in, pulse durations out.
//
// The block turns command bytes into a pulse-distance IR or RF frame. A byte is
// transferred on the input channel when in_valid_i is high and in_stall_o is low.
// Its bits, most significant first, select the zero, one or raw pulse list; the
// header list precedes the first bit of a frame and the trail list follows bit
// frame_bits-1, after which the bit counter starts a new frame.
// Each pulse goes out on the output channel as one transfer, taken when
// out_valid_o is high and out_stall_i is low. last_of_run_o marks the final pulse
// of a byte, frame_done_o marks it when that byte completes a frame.
// Configuration is written through cfg_valid_i, cfg_index_i and cfg_data_i;
// cfg_ready_o is always high. The user must make writes only while the block is
// idle; the block itself does not enforce this. One byte occupies the block for an
// acceptance step, a step for each examined pulse slot (up to four slots per
// list, up to ten lists) and a flush step. A single slot selector walks the lists
// one slot a cycle while the output register is free. Each pulse waits in a holding
// register until the next pulse or the end of the byte is known, so it passes
// through the holding register and then the output register. While the receiver
// stalls, the sequencer waits and the output register holds. Reset returns the
// configuration to its defaults and starts a new frame.
module ir_pulse_train_encoder
  import irpte_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             cmd_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [PULSE_WIDTH-1:0] pulse_duration_o,
  output logic                   last_of_run_o,
  output logic                   frame_done_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_HEAD  = 3'd1;
  localparam logic [2:0] ST_BITS  = 3'd2;
  localparam logic [2:0] ST_TRAIL = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [LIST_WIDTH-1:0] header_q, zero_q, one_q, trail_q, raw_q;
  logic [7:0]            frame_bits_q, raw_bit_index_q;
  logic                  raw_enable_q;

  logic [2:0]            state_q, state_d;
  logic [7:0]            bit_pos_q, bit_pos_d;
  logic [7:0]            byte_q, byte_d;
  logic [7:0]            start_pos_q, start_pos_d;
  logic [3:0]            n_q, n_d;
  logic [2:0]            i_q, i_d;
  logic                  done_q, done_d;
  logic [SLOT_IDX_W-1:0] slot_q, slot_d;
  logic [PULSE_WIDTH-1:0] pend_q, pend_d;
  logic                  pend_v_q, pend_v_d;
  logic                  out_v_q, out_v_d;
  logic [PULSE_WIDTH-1:0] out_dur_q, out_dur_d;
  logic                  out_last_q, out_last_d;
  logic                  out_done_q, out_done_d;

  logic                  in_xfer, out_free;
  logic [7:0]            remain;
  logic [8:0]            cur_bit;
  logic [LIST_WIDTH-1:0] cur_list;
  logic [PULSE_WIDTH-1:0] slot_dur;
  logic [2:0]            after_bits;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_v_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign remain      = frame_bits_q - bit_pos_q;
  assign cur_bit     = {1'b0, start_pos_q} + {6'd0, i_q};
  assign after_bits  = done_q ? ST_TRAIL : ST_FLUSH;

  always_comb begin
    unique case (state_q)
      ST_HEAD:  cur_list = header_q;
      ST_TRAIL: cur_list = trail_q;
      ST_BITS: begin
        if (raw_enable_q && (cur_bit == {1'b0, raw_bit_index_q})) begin
          cur_list = raw_q;
        end else if (byte_q[3'd7 - i_q]) begin
          cur_list = one_q;
        end else begin
          cur_list = zero_q;
        end
      end
      default:  cur_list = trail_q;
    endcase
    slot_dur = cur_list[slot_q*PULSE_WIDTH +: PULSE_WIDTH];
  end

  always_comb begin
    state_d     = state_q;
    bit_pos_d   = bit_pos_q;
    byte_d      = byte_q;
    start_pos_d = start_pos_q;
    n_d         = n_q;
    i_d         = i_q;
    done_d      = done_q;
    slot_d      = slot_q;
    pend_d      = pend_q;
    pend_v_d    = pend_v_q;
    out_v_d     = out_v_q && out_stall_i;
    out_dur_d   = out_dur_q;
    out_last_d  = out_last_q;
    out_done_d  = out_done_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          byte_d      = cmd_byte_i;
          start_pos_d = bit_pos_q;
          i_d         = 3'd0;
          slot_d      = '0;
          pend_v_d    = 1'b0;
          if (bit_pos_q >= frame_bits_q) begin
            n_d    = 4'd0;
            done_d = 1'b1;
          end else begin
            n_d    = (remain > BITS_PER_BYTE) ? 4'd8 : remain[3:0];
            done_d = (remain <= BITS_PER_BYTE);
          end
          if (done_d) begin
            bit_pos_d = 8'd0;
          end else begin
            bit_pos_d = bit_pos_q + {4'd0, n_d};
          end
          if (bit_pos_q == 8'd0) begin
            state_d = ST_HEAD;
          end else if (n_d != 4'd0) begin
            state_d = ST_BITS;
          end else begin
            state_d = done_d ? ST_TRAIL : ST_FLUSH;
          end
        end
      end
      ST_HEAD, ST_BITS, ST_TRAIL: begin
        if (out_free) begin
          if (slot_dur != '0) begin
            if (pend_v_q) begin
              out_v_d    = 1'b1;
              out_dur_d  = pend_q;
              out_last_d = 1'b0;
              out_done_d = 1'b0;
            end
            pend_d   = slot_dur;
            pend_v_d = 1'b1;
          end
          if ((slot_dur == '0) || (slot_q == LAST_SLOT)) begin
            slot_d = '0;
            if (state_q == ST_HEAD) begin
              state_d = (n_q != 4'd0) ? ST_BITS : after_bits;
            end else if (state_q == ST_BITS) begin
              if (({1'b0, i_q} + 4'd1) < n_q) begin
                i_d = i_q + 3'd1;
              end else begin
                state_d = after_bits;
              end
            end else begin
              state_d = ST_FLUSH;
            end
          end else begin
            slot_d = slot_q + SLOT_IDX_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          if (pend_v_q) begin
            out_v_d    = 1'b1;
            out_dur_d  = pend_q;
            out_last_d = 1'b1;
            out_done_d = done_q;
          end
          pend_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q        <= '0;
      zero_q          <= '0;
      one_q           <= '0;
      trail_q         <= '0;
      raw_q           <= '0;
      frame_bits_q    <= FRAME_BITS_RESET;
      raw_bit_index_q <= 8'd0;
      raw_enable_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_HEADER_PULSES: header_q        <= cfg_data_i[LIST_WIDTH-1:0];
        REG_ZERO_PULSES:   zero_q          <= cfg_data_i[LIST_WIDTH-1:0];
        REG_ONE_PULSES:    one_q           <= cfg_data_i[LIST_WIDTH-1:0];
        REG_TRAIL_PULSES:  trail_q         <= cfg_data_i[LIST_WIDTH-1:0];
        REG_RAW_PULSES:    raw_q           <= cfg_data_i[LIST_WIDTH-1:0];
        REG_FRAME_BITS:    frame_bits_q    <= cfg_data_i[7:0];
        REG_RAW_BIT_INDEX: raw_bit_index_q <= cfg_data_i[7:0];
        REG_RAW_ENABLE:    raw_enable_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      bit_pos_q <= 8'd0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
      n_q       <= 4'd0;
      i_q       <= 3'd0;
      done_q    <= 1'b0;
      slot_q    <= '0;
    end else begin
      state_q   <= state_d;
      bit_pos_q <= bit_pos_d;
      pend_v_q  <= pend_v_d;
      out_v_q   <= out_v_d;
      n_q       <= n_d;
      i_q       <= i_d;
      done_q    <= done_d;
      slot_q    <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q      <= byte_d;
    start_pos_q <= start_pos_d;
    pend_q      <= pend_d;
    out_dur_q   <= out_dur_d;
    out_last_q  <= out_last_d;
    out_done_q  <= out_done_d;
  end

  assign out_valid_o      = out_v_q;
  assign pulse_duration_o = out_dur_q;
  assign last_of_run_o    = out_last_q;
  assign frame_done_o     = out_done_q;

endmodule
